FILE: rtl/tvp_pkg.sv
package tvp_pkg;

    localparam int unsigned POS_W   = 32;
    localparam int unsigned SPD_W   = 24;
    localparam int unsigned FRAC_W  = 17;
    localparam int unsigned DIST_W  = 32;
    localparam int unsigned RAMP_W  = 33;
    localparam int unsigned SQ_W    = 48;
    localparam int unsigned PROD_W  = 80;
    localparam int unsigned QUO_W   = 52;
    localparam int unsigned V2_W    = 51;
    localparam int unsigned ROOT_W  = 26;
    localparam int unsigned SREM_W  = 28;
    localparam int unsigned OUT_W   = 25;

    localparam logic [2:0] REG_START_POS   = 3'd0;
    localparam logic [2:0] REG_END_POS     = 3'd1;
    localparam logic [2:0] REG_START_SPEED = 3'd2;
    localparam logic [2:0] REG_PEAK_SPEED  = 3'd3;
    localparam logic [2:0] REG_FINAL_SPEED = 3'd4;
    localparam logic [2:0] REG_ACCEL_FRAC  = 3'd5;
    localparam logic [2:0] REG_DECEL_FRAC  = 3'd6;

    localparam logic [FRAC_W-1:0] ACCEL_FRAC_RST = 17'd13107;
    localparam logic [FRAC_W-1:0] DECEL_FRAC_RST = 17'd19661;

    localparam logic signed [33:0] ARRIVE_BAND = 34'sd512;
    localparam logic [V2_W-1:0]    V2_CAP      = 51'h4_0000_0000_0000;
    localparam logic [SPD_W-1:0]   SPEED_MAX   = 24'hFF_FFFF;

    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_ARRIVE = 2'd3;

    typedef struct packed {
        logic [SQ_W-1:0]   base;
        logic              dneg;
        logic [RAMP_W-1:0] den;
        logic              qz;
        logic              ovf;
        logic [1:0]        phase;
        logic              neg;
    } t_dctl;

    typedef struct packed {
        logic [1:0] phase;
        logic       neg;
    } t_sctl;

endpackage

FILE: rtl/trapezoid_velocity_profile_top.sv
// throughput: one item per cycle while the output is not stalled; a 52-stage
// restoring divider and a 26-stage square-root pipeline, one bit per stage,
// set the latency
// all stages advance together and hold while the output is stalled
// reset (synchronous, active low) clears the valid bits and loads the configuration defaults
module trapezoid_velocity_profile_top import tvp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] position
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [24:0] target_speed, [31:25] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] phase
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    logic en;
    assign en = ~o_m_axis_tvalid | i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_cfg_ready = 1'b1;

    // configuration
    logic [POS_W-1:0]  r_start_pos, r_end_pos;
    logic [SPD_W-1:0]  r_start_speed, r_peak_speed, r_final_speed;
    logic [FRAC_W-1:0] r_accel_frac, r_decel_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pos   <= '0;
            r_end_pos     <= '0;
            r_start_speed <= '0;
            r_peak_speed  <= '0;
            r_final_speed <= '0;
            r_accel_frac  <= ACCEL_FRAC_RST;
            r_decel_frac  <= DECEL_FRAC_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_START_POS:   r_start_pos   <= i_cfg_data;
                REG_END_POS:     r_end_pos     <= i_cfg_data;
                REG_START_SPEED: r_start_speed <= i_cfg_data[SPD_W-1:0];
                REG_PEAK_SPEED:  r_peak_speed  <= i_cfg_data[SPD_W-1:0];
                REG_FINAL_SPEED: r_final_speed <= i_cfg_data[SPD_W-1:0];
                REG_ACCEL_FRAC:  r_accel_frac  <= i_cfg_data[FRAC_W-1:0];
                REG_DECEL_FRAC:  r_decel_frac  <= i_cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // move constants derived from configuration, registered and not held by the output stall
    logic [DIST_W-1:0]    r_ssu;
    logic [RAMP_W-1:0]    r_sac, r_sde;
    logic signed [33:0]   r_cru;
    logic [SQ_W-1:0]      r_vs2, r_vp2, r_vf2;
    logic signed [SQ_W:0] r_dacc, r_ddec;
    logic signed [32:0]   pdiff;
    logic [48:0]          sac_prod, sde_prod;

    assign pdiff    = $signed({r_end_pos[31], r_end_pos}) - $signed({r_start_pos[31], r_start_pos});
    assign sac_prod = {17'd0, r_ssu} * {32'd0, r_accel_frac};
    assign sde_prod = {17'd0, r_ssu} * {32'd0, r_decel_frac};

    always_ff @(posedge i_clk) begin
        r_ssu  <= pdiff[32] ? 32'(-pdiff) : pdiff[31:0];
        r_sac  <= sac_prod[48:16];
        r_sde  <= sde_prod[48:16];
        r_cru  <= $signed({2'b00, r_ssu}) - $signed({1'b0, r_sde});
        r_vs2  <= {24'd0, r_start_speed} * {24'd0, r_start_speed};
        r_vp2  <= {24'd0, r_peak_speed} * {24'd0, r_peak_speed};
        r_vf2  <= {24'd0, r_final_speed} * {24'd0, r_final_speed};
        r_dacc <= $signed({1'b0, r_vp2}) - $signed({1'b0, r_vs2});
        r_ddec <= $signed({1'b0, r_vp2}) - $signed({1'b0, r_vf2});
    end

    // front stages
    logic [4:0]         r_v;
    logic [POS_W-1:0]   r_pos0;
    logic [DIST_W-1:0]  r_s1, r_s2;
    logic               r_neg1, r_neg2, r_neg3, r_neg4;
    logic signed [33:0] r_d2;
    logic               r_acc2;
    logic signed [32:0] sdiff;

    logic [SQ_W-1:0]    r_base3, r_mag3, r_base4;
    logic               r_dneg3, r_dneg4, r_qz3, r_qz4;
    logic [DIST_W-1:0]  r_num3;
    logic [RAMP_W-1:0]  r_den3, r_den4;
    logic [1:0]         r_ph3, r_ph4;
    logic [55:0]        r_plo4, r_phi4;

    logic               cru3, arr3;
    logic [33:0]        dabs;
    logic [SQ_W-1:0]    amag, dmag;

    assign sdiff = $signed({r_pos0[31], r_pos0}) - $signed({r_start_pos[31], r_start_pos});
    assign cru3  = $signed({2'b00, r_s2}) < r_cru;
    assign arr3  = r_d2 <= ARRIVE_BAND;
    assign dabs  = r_d2[33] ? 34'(-r_d2) : r_d2;
    assign amag  = r_dacc[SQ_W] ? SQ_W'(-r_dacc) : r_dacc[SQ_W-1:0];
    assign dmag  = r_ddec[SQ_W] ? SQ_W'(-r_ddec) : r_ddec[SQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[3:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos0 <= i_s_axis_tdata;

            r_s1   <= sdiff[32] ? 32'(-sdiff) : sdiff[31:0];
            r_neg1 <= $signed(r_end_pos) < $signed(r_start_pos);

            r_s2   <= r_s1;
            r_d2   <= $signed({2'b00, r_ssu}) - $signed({2'b00, r_s1});
            r_acc2 <= {1'b0, r_s1} < r_sac;
            r_neg2 <= r_neg1;

            r_neg3 <= r_neg2;
            if (arr3) begin
                r_ph3   <= PH_ARRIVE;
                r_base3 <= '0;
                r_mag3  <= '0;
                r_dneg3 <= 1'b0;
                r_num3  <= '0;
                r_den3  <= r_sde;
                r_qz3   <= 1'b1;
            end else if (r_acc2) begin
                r_ph3   <= PH_ACCEL;
                r_base3 <= r_vs2;
                r_mag3  <= amag;
                r_dneg3 <= r_dacc[SQ_W];
                r_num3  <= r_s2;
                r_den3  <= r_sac;
                r_qz3   <= 1'b0;
            end else if (cru3) begin
                // peak squared passes the root unchanged
                r_ph3   <= PH_CRUISE;
                r_base3 <= r_vp2;
                r_mag3  <= '0;
                r_dneg3 <= 1'b0;
                r_num3  <= '0;
                r_den3  <= r_sde;
                r_qz3   <= 1'b1;
            end else begin
                r_ph3   <= PH_DECEL;
                r_base3 <= r_vf2;
                r_mag3  <= dmag;
                r_dneg3 <= r_ddec[SQ_W];
                r_num3  <= dabs[DIST_W-1:0];
                r_den3  <= r_sde;
                r_qz3   <= (r_sde == '0);
            end

            r_plo4  <= {32'd0, r_mag3[23:0]} * {24'd0, r_num3};
            r_phi4  <= {32'd0, r_mag3[47:24]} * {24'd0, r_num3};
            r_base4 <= r_base3;
            r_dneg4 <= r_dneg3;
            r_den4  <= r_den3;
            r_qz4   <= r_qz3;
            r_ph4   <= r_ph3;
            r_neg4  <= r_neg3;
        end
    end

    // divider: one quotient bit per stage
    logic [PROD_W-1:0] prod5;
    assign prod5 = {r_phi4, 24'd0} + {24'd0, r_plo4};

    logic [QUO_W:0]    r_dv_v;
    t_dctl             r_dv_c   [QUO_W+1];
    logic [RAMP_W-1:0] r_dv_rem [QUO_W+1];
    logic [QUO_W-1:0]  r_dv_wrd [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v <= '0;
        end else if (en) begin
            r_dv_v <= {r_dv_v[QUO_W-1:0], r_v[4]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_c[0].base  <= r_base4;
            r_dv_c[0].dneg  <= r_dneg4;
            r_dv_c[0].den   <= r_den4;
            r_dv_c[0].qz    <= r_qz4;
            r_dv_c[0].ovf   <= {5'd0, prod5[PROD_W-1:QUO_W]} >= r_den4;
            r_dv_c[0].phase <= r_ph4;
            r_dv_c[0].neg   <= r_neg4;
            r_dv_rem[0]     <= {5'd0, prod5[PROD_W-1:QUO_W]};
            r_dv_wrd[0]     <= prod5[QUO_W-1:0];
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        logic [RAMP_W:0] t;
        logic            ge;
        assign t  = {r_dv_rem[k], r_dv_wrd[k][QUO_W-1]};
        assign ge = t >= {1'b0, r_dv_c[k].den};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_c[k+1]   <= r_dv_c[k];
                r_dv_rem[k+1] <= ge ? RAMP_W'(t - {1'b0, r_dv_c[k].den}) : t[RAMP_W-1:0];
                r_dv_wrd[k+1] <= {r_dv_wrd[k][QUO_W-2:0], ge};
            end
        end
    end

    // ramp term applied, clamped to the root range
    t_dctl              dc;
    logic [QUO_W:0]     q;
    logic signed [54:0] v2s;
    assign dc  = r_dv_c[QUO_W];
    assign q   = dc.qz ? '0 : (dc.ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, r_dv_wrd[QUO_W]});
    assign v2s = dc.dneg ? $signed({7'd0, dc.base}) - $signed({2'b00, q})
                         : $signed({7'd0, dc.base}) + $signed({2'b00, q});

    logic [ROOT_W:0]   r_sq_v;
    t_sctl             r_sq_c   [ROOT_W+1];
    logic [2*ROOT_W-1:0] r_sq_x [ROOT_W+1];
    logic [SREM_W-1:0] r_sq_rem [ROOT_W+1];
    logic [ROOT_W-1:0] r_sq_rt  [ROOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= '0;
        end else if (en) begin
            r_sq_v <= {r_sq_v[ROOT_W-1:0], r_dv_v[QUO_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_c[0].phase <= dc.phase;
            r_sq_c[0].neg   <= dc.neg;
            if (v2s < 0) begin
                r_sq_x[0] <= '0;
            end else if (v2s > $signed({4'd0, V2_CAP})) begin
                r_sq_x[0] <= {1'b0, V2_CAP};
            end else begin
                r_sq_x[0] <= {1'b0, v2s[V2_W-1:0]};
            end
            r_sq_rem[0] <= '0;
            r_sq_rt[0]  <= '0;
        end
    end

    // square root: one result bit per stage
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        logic [SREM_W+1:0] t;
        logic [SREM_W+1:0] trial;
        logic              ge;
        assign t     = {r_sq_rem[j], r_sq_x[j][2*ROOT_W-1:2*ROOT_W-2]};
        assign trial = {2'b00, r_sq_rt[j], 2'b01};
        assign ge    = t >= trial;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_c[j+1]   <= r_sq_c[j];
                r_sq_x[j+1]   <= {r_sq_x[j][2*ROOT_W-3:0], 2'b00};
                r_sq_rem[j+1] <= ge ? SREM_W'(t - trial) : t[SREM_W-1:0];
                r_sq_rt[j+1]  <= {r_sq_rt[j][ROOT_W-2:0], ge};
            end
        end
    end

    // saturate, apply direction
    logic [SPD_W-1:0] vsat;
    logic [OUT_W-1:0] vout;
    assign vsat = (r_sq_rt[ROOT_W][ROOT_W-1:SPD_W] != '0) ? SPEED_MAX
                                                          : r_sq_rt[ROOT_W][SPD_W-1:0];
    assign vout = r_sq_c[ROOT_W].neg ? OUT_W'(-{1'b0, vsat}) : {1'b0, vsat};

    logic             r_out_v;
    logic [OUT_W-1:0] r_out_spd;
    logic [1:0]       r_out_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_sq_v[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_spd <= vout;
            r_out_ph  <= r_sq_c[ROOT_W].phase;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {7'd0, r_out_spd};
    assign o_m_axis_tuser  = r_out_ph;

endmodule
